// ===== rtl/core/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared register map, bit positions and FIFO control types for the SPI
// master FIFO controller.
// ----------------------------------------------------------------------------
package sfc_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // register byte offsets
    localparam logic [6:0] ADDR_GIE = 7'h1c;
    localparam logic [6:0] ADDR_ISR = 7'h20;
    localparam logic [6:0] ADDR_IER = 7'h28;
    localparam logic [6:0] ADDR_SRR = 7'h40;
    localparam logic [6:0] ADDR_CR  = 7'h62;
    localparam logic [6:0] ADDR_SR  = 7'h67;
    localparam logic [6:0] ADDR_DTR = 7'h6b;
    localparam logic [6:0] ADDR_DRR = 7'h6f;
    localparam logic [6:0] ADDR_SSR = 7'h70;

    localparam logic [31:0] SRR_KEY = 32'h0000_000a;
    localparam int          GIE_BIT = 31;

    localparam logic [8:0] CR_RESET      = 9'h180;
    localparam logic [8:0] CR_STORE_MASK = 9'h19f;
    localparam int CR_ENABLE  = 1;
    localparam int CR_MASTER  = 2;
    localparam int CR_CPOL    = 3;
    localparam int CR_CPHA    = 4;
    localparam int CR_TXRST   = 5;
    localparam int CR_RXRST   = 6;
    localparam int CR_INHIBIT = 8;

    localparam int ISR_TX_EMPTY   = 2;
    localparam int ISR_RX_FULL    = 4;
    localparam int ISR_RX_OVERRUN = 5;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
    } fifo_stat_t;

endpackage

// ===== rtl/core/spi_master_fifo_controller_unit.sv =====
// Flow: a beat accepted on s_ is held in the input register, worked on in one
// pass, and its result is held in the output register that drives m_.
// Throughput: one beat per cycle while m_ is not stalled; each beat needs at
// most one push or pop per FIFO and a one-bit shift in one processing stage.
// Reset: aresetn (synchronous, active low) clears all control state and
// empties both FIFOs; a write of 0x0a to the reset register does the same.
// ----------------------------------------------------------------------------
// spi_master_fifo_controller_unit
// Register map, FIFOs and bit-time shift engine of an 8-bit SPI master,
// driven by bus read, bus write and tick beats.
// ----------------------------------------------------------------------------
module spi_master_fifo_controller_unit #(
    parameter int FIFO_DEPTH   = 16,
    parameter int SELECT_LINES = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tdata: address[6:0], write_data[38:7], miso_bit[39]
    input  logic [sfc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]                       s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: read_data[31:0], mosi_bit[32], bit_shifted[33],
    //        clock_idle_level[34], clock_phase[35], slave_select[51:36],
    //        interrupt_request[52], zero[55:53]
    output logic [sfc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready
);
    import sfc_pkg::*;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_mode_reg;
    logic [6:0]  in_addr_reg;
    logic [31:0] in_wdata_reg;
    logic        in_miso_reg;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [OUT_TDATA_W-1:0] m_data_next;

    // block state
    logic [8:0]              ctrl_reg, ctrl_next;
    logic [7:0]              shift_reg, shift_next;
    logic [2:0]              bit_idx_reg, bit_idx_next;
    logic                    shifting_reg, shifting_next;
    logic [SELECT_LINES-1:0] sel_reg, sel_next;
    logic [5:0]              isr_reg, isr_next;
    logic [5:0]              ier_reg, ier_next;
    logic                    gie_reg, gie_next;

    fifo_ctrl_t tx_ctrl, rx_ctrl;
    fifo_stat_t tx_stat, rx_stat;
    logic [7:0] tx_head, rx_head;
    logic [7:0] rx_wdata;

    logic        advance;
    logic        fire;
    logic        spi_enabled;
    logic [7:0]  byte_cur;
    logic [7:0]  byte_new;
    logic [31:0] rdata;
    logic        mosi;
    logic        shifted;
    logic [31:0] sel_ext;
    logic        irq;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    assign m_valid_next  = fire ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    assign spi_enabled = ctrl_reg[CR_ENABLE] && ctrl_reg[CR_MASTER] && !ctrl_reg[CR_INHIBIT];
    assign byte_cur    = shifting_reg ? shift_reg : tx_head;
    assign byte_new    = {byte_cur[6:0], in_miso_reg};

    always_comb begin
        ctrl_next     = ctrl_reg;
        shift_next    = shift_reg;
        bit_idx_next  = bit_idx_reg;
        shifting_next = shifting_reg;
        sel_next      = sel_reg;
        isr_next      = isr_reg;
        ier_next      = ier_reg;
        gie_next      = gie_reg;
        tx_ctrl       = '0;
        rx_ctrl       = '0;
        rx_wdata      = byte_new;
        rdata         = '0;
        mosi          = 1'b0;
        shifted       = 1'b0;

        if (fire) begin
            case (in_mode_reg)
                MODE_READ: begin
                    case (in_addr_reg)
                        ADDR_GIE: rdata[GIE_BIT] = gie_reg;
                        ADDR_ISR: rdata = 32'(isr_reg);
                        ADDR_IER: rdata = 32'(ier_reg);
                        ADDR_CR:  rdata = 32'(ctrl_reg);
                        ADDR_SR:  rdata = {28'd0, tx_stat.full, tx_stat.empty,
                                           rx_stat.full, rx_stat.empty};
                        ADDR_DRR: begin
                            if (!rx_stat.empty) begin
                                rdata       = 32'(rx_head);
                                rx_ctrl.pop = 1'b1;
                            end
                        end
                        ADDR_SSR: rdata = 32'(sel_reg);
                        default:  rdata = '0;
                    endcase
                end
                MODE_WRITE: begin
                    case (in_addr_reg)
                        ADDR_GIE: gie_next = in_wdata_reg[GIE_BIT];
                        ADDR_ISR: isr_next = isr_reg & ~in_wdata_reg[5:0];
                        ADDR_IER: ier_next = in_wdata_reg[5:0];
                        ADDR_SRR: begin
                            if (in_wdata_reg == SRR_KEY) begin
                                ctrl_next     = CR_RESET;
                                shift_next    = '0;
                                bit_idx_next  = '0;
                                shifting_next = 1'b0;
                                sel_next      = '1;
                                isr_next      = '0;
                                ier_next      = '0;
                                gie_next      = 1'b0;
                                tx_ctrl.clear = 1'b1;
                                rx_ctrl.clear = 1'b1;
                            end
                        end
                        ADDR_CR: begin
                            tx_ctrl.clear = in_wdata_reg[CR_TXRST];
                            rx_ctrl.clear = in_wdata_reg[CR_RXRST];
                            ctrl_next     = in_wdata_reg[8:0] & CR_STORE_MASK;
                        end
                        ADDR_DTR: tx_ctrl.push = 1'b1;
                        ADDR_SSR: sel_next = in_wdata_reg[SELECT_LINES-1:0];
                        default:  ;
                    endcase
                end
                MODE_TICK: begin
                    if (spi_enabled && (shifting_reg || !tx_stat.empty)) begin
                        // load a fresh byte when none is in flight
                        tx_ctrl.pop = !shifting_reg;
                        mosi        = byte_cur[7];
                        shifted     = 1'b1;
                        shift_next  = byte_new;
                        if (bit_idx_reg == 3'd7) begin
                            shifting_next = 1'b0;
                            bit_idx_next  = '0;
                            if (rx_stat.full) begin
                                isr_next[ISR_RX_OVERRUN] = 1'b1;
                            end else begin
                                rx_ctrl.push = 1'b1;
                            end
                            if (rx_stat.full || rx_stat.one_left) begin
                                isr_next[ISR_RX_FULL] = 1'b1;
                            end
                            if (tx_stat.empty) begin
                                isr_next[ISR_TX_EMPTY] = 1'b1;
                            end
                        end else begin
                            shifting_next = 1'b1;
                            bit_idx_next  = bit_idx_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign sel_ext = 32'(sel_next);
    assign irq     = gie_next && ((isr_next & ier_next) != '0);

    assign m_data_next = {3'b000, irq, sel_ext[15:0], ctrl_next[CR_CPHA],
                          ctrl_next[CR_CPOL], shifted, mosi, rdata};

    sfc_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tx_ctrl),
        .wr_data   (in_wdata_reg[7:0]),
        .head_data (tx_head),
        .stat      (tx_stat)
    );

    sfc_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rx_ctrl),
        .wr_data   (rx_wdata),
        .head_data (rx_head),
        .stat      (rx_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            ctrl_reg     <= CR_RESET;
            shift_reg    <= '0;
            bit_idx_reg  <= '0;
            shifting_reg <= 1'b0;
            sel_reg      <= '1;
            isr_reg      <= '0;
            ier_reg      <= '0;
            gie_reg      <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            ctrl_reg     <= ctrl_next;
            shift_reg    <= shift_next;
            bit_idx_reg  <= bit_idx_next;
            shifting_reg <= shifting_next;
            sel_reg      <= sel_next;
            isr_reg      <= isr_next;
            ier_reg      <= ier_next;
            gie_reg      <= gie_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg  <= s_tuser;
            in_addr_reg  <= s_tdata[6:0];
            in_wdata_reg <= s_tdata[38:7];
            in_miso_reg  <= s_tdata[39];
        end
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_idle_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !shifting_reg |-> (bit_idx_reg == '0))
        else $error("bit index nonzero with no byte in flight");

    a_rx_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rx_stat.full && rx_stat.empty))
        else $error("receive FIFO reports full and empty at once");

    a_result_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg))
        else $error("result beat appeared without a registered input beat");
`endif

endmodule

// ===== rtl/core/sfc_fifo.sv =====
// ----------------------------------------------------------------------------
// sfc_fifo
// Byte FIFO on a one-write one-read memory with a registered head word
// that always shows the oldest entry.
// ----------------------------------------------------------------------------
module sfc_fifo #(
    parameter int DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sfc_pkg::fifo_ctrl_t ctrl,
    input  logic [7:0]         wr_data,
    output logic [7:0]         head_data,
    output sfc_pkg::fifo_stat_t stat
);
    import sfc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       head_reg;
    logic             push_ok;
    logic             pop_ok;

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.one_left = (count_reg == CNT_W'(DEPTH - 1));

    assign push_ok = ctrl.push && !ctrl.clear && !stat.full;
    assign pop_ok  = ctrl.pop && !ctrl.clear && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.clear) begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end else begin
            if (push_ok) begin
                wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_ok) begin
                rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_next = count_reg + CNT_W'(push_ok) - CNT_W'(pop_ok);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // prefetch the next head; forward a byte written into that slot this cycle
    always_ff @(posedge aclk) begin
        if (push_ok && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= wr_data;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign head_data = head_reg;

endmodule

// ===== tb/spi_master_fifo_controller_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_master_fifo_controller_unit_test
// Drives bus read, bus write and bit-time tick beats into the SPI master
// controller and predicts every result beat from a local copy of the register
// map, both FIFOs and the shift engine. Short directed checks come first, then
// randomized transfers with register traffic, noise, gaps and back-pressure.
// ----------------------------------------------------------------------------
module spi_master_fifo_controller_unit_test;
    import sfc_pkg::*;

    localparam int FIFO_SLOTS  = 16;
    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 500_000;

    // result beat as laid out on m_tdata, lowest field last
    typedef struct packed {
        logic [2:0]  pad;
        logic        irq;
        logic [15:0] ss;
        logic        cpha;
        logic        cpol;
        logic        shifted;
        logic        mosi;
        logic [31:0] rdata;
    } spi_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;

    spi_master_fifo_controller_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // local copy of the block state
    logic [8:0]  ctrl_reg;
    logic [7:0]  tx_fifo[$];
    logic [7:0]  rx_fifo[$];
    logic [7:0]  shift_reg;
    logic [3:0]  bit_cnt;
    logic        in_flight;
    logic [15:0] ssel_reg;
    logic [5:0]  isr_reg;
    logic [5:0]  ier_reg;
    logic        gie_reg;

    spi_result_t predicted_replies[$];

    int items_sent;
    int results_seen;
    int mismatch_count;
    int gap_style;
    int n_reads, n_writes, n_ticks, bytes_exchanged, bytes_dropped, soft_resets;

    logic [6:0] reg_addrs[9] = '{ADDR_GIE, ADDR_ISR, ADDR_IER, ADDR_SRR, ADDR_CR,
                                 ADDR_SR, ADDR_DTR, ADDR_DRR, ADDR_SSR};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("spi_master_fifo_controller_unit_test failed");
        $finish;
    end

    function automatic void model_reset();
        ctrl_reg  = CR_RESET;
        tx_fifo.delete();
        rx_fifo.delete();
        shift_reg = '0;
        bit_cnt   = '0;
        in_flight = 1'b0;
        ssel_reg  = 16'hffff;
        isr_reg   = '0;
        ier_reg   = '0;
        gie_reg   = 1'b0;
    endfunction

    function automatic void spi_predict(input logic [1:0] mode, input logic [6:0] addr,
                                        input logic [31:0] data, input logic miso);
        spi_result_t r;
        r = '0;
        case (mode)
            MODE_READ: begin
                n_reads++;
                case (addr)
                    ADDR_GIE: r.rdata = {gie_reg, 31'b0};
                    ADDR_ISR: r.rdata = {26'b0, isr_reg};
                    ADDR_IER: r.rdata = {26'b0, ier_reg};
                    ADDR_CR:  r.rdata = {23'b0, ctrl_reg};
                    ADDR_SR:  r.rdata = {28'b0, tx_fifo.size() >= FIFO_SLOTS,
                                         tx_fifo.size() == 0,
                                         rx_fifo.size() >= FIFO_SLOTS,
                                         rx_fifo.size() == 0};
                    ADDR_DRR: if (rx_fifo.size() != 0) r.rdata = {24'b0, rx_fifo.pop_front()};
                    ADDR_SSR: r.rdata = {16'b0, ssel_reg};
                    default:  r.rdata = '0;
                endcase
            end
            MODE_WRITE: begin
                n_writes++;
                case (addr)
                    ADDR_GIE: gie_reg = data[GIE_BIT];
                    ADDR_ISR: isr_reg = isr_reg & ~data[5:0];
                    ADDR_IER: ier_reg = data[5:0];
                    ADDR_SRR: if (data == SRR_KEY) begin
                        model_reset();
                        soft_resets++;
                    end
                    ADDR_CR: begin
                        if (data[CR_TXRST]) tx_fifo.delete();
                        if (data[CR_RXRST]) rx_fifo.delete();
                        ctrl_reg = data[8:0] & CR_STORE_MASK;
                    end
                    ADDR_DTR: if (tx_fifo.size() < FIFO_SLOTS) tx_fifo.push_back(data[7:0]);
                    ADDR_SSR: ssel_reg = data[15:0];
                    default: ;
                endcase
            end
            MODE_TICK: begin
                n_ticks++;
                if (ctrl_reg[CR_ENABLE] && ctrl_reg[CR_MASTER] && !ctrl_reg[CR_INHIBIT]
                        && (in_flight || tx_fifo.size() != 0)) begin
                    if (!in_flight) begin
                        shift_reg = tx_fifo.pop_front();
                        bit_cnt   = '0;
                        in_flight = 1'b1;
                    end
                    r.mosi    = shift_reg[7];
                    r.shifted = 1'b1;
                    shift_reg = {shift_reg[6:0], miso};
                    bit_cnt++;
                    if (bit_cnt == 4'd8) begin
                        in_flight = 1'b0;
                        bit_cnt   = '0;
                        bytes_exchanged++;
                        // drop the byte when the receive side has no room
                        if (rx_fifo.size() >= FIFO_SLOTS) begin
                            isr_reg[ISR_RX_OVERRUN] = 1'b1;
                            bytes_dropped++;
                        end else begin
                            rx_fifo.push_back(shift_reg);
                        end
                        if (rx_fifo.size() >= FIFO_SLOTS) isr_reg[ISR_RX_FULL] = 1'b1;
                        if (tx_fifo.size() == 0) isr_reg[ISR_TX_EMPTY] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.cpol = ctrl_reg[CR_CPOL];
        r.cpha = ctrl_reg[CR_CPHA];
        r.ss   = ssel_reg;
        r.irq  = gie_reg && ((isr_reg & ier_reg) != 0);
        predicted_replies.push_back(r);
    endfunction

    function automatic int pick_gap();
        int pick;
        if (gap_style == 0) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic send_beat(input logic [1:0] mode, input logic [6:0] addr,
                             input logic [31:0] data, input logic miso);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {miso, data, addr};
        do @(posedge aclk); while (!s_tready);
        spi_predict(mode, addr, data, miso);
        items_sent++;
    endtask

    task automatic reg_read(input logic [6:0] addr);
        send_beat(MODE_READ, addr, $urandom, $urandom_range(0, 1));
    endtask

    task automatic reg_write(input logic [6:0] addr, input logic [31:0] data);
        send_beat(MODE_WRITE, addr, data, $urandom_range(0, 1));
    endtask

    task automatic spi_tick(input logic miso);
        send_beat(MODE_TICK, 7'($urandom), $urandom, miso);
    endtask

    // hold the sender until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (predicted_replies.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
                     $realtime, results_seen, what, got_v, want_v);
    endtask

    initial begin : result_sink
        int pick;
        int run_len;
        forever begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                m_tready <= 1'b1;
                run_len = $urandom_range(1, 40);
            end else if (pick < 92) begin
                m_tready <= 1'b0;
                run_len = $urandom_range(1, 3);
            end else begin
                m_tready <= 1'b0;
                run_len = $urandom_range(8, 30);
            end
            repeat (run_len) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        spi_result_t got;
        spi_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = spi_result_t'(m_tdata);
            results_seen++;
            if (predicted_replies.size() == 0) begin
                report_mismatch("unexpected beat, read_data", got.rdata, '0);
            end else begin
                want = predicted_replies.pop_front();
                if (got.rdata   !== want.rdata)   report_mismatch("read_data", got.rdata, want.rdata);
                if (got.mosi    !== want.mosi)    report_mismatch("mosi_bit", got.mosi, want.mosi);
                if (got.shifted !== want.shifted) report_mismatch("bit_shifted", got.shifted,
                                                                  want.shifted);
                if (got.cpol    !== want.cpol)    report_mismatch("clock_idle_level", got.cpol,
                                                                  want.cpol);
                if (got.cpha    !== want.cpha)    report_mismatch("clock_phase", got.cpha, want.cpha);
                if (got.ss      !== want.ss)      report_mismatch("slave_select", got.ss, want.ss);
                if (got.irq     !== want.irq)     report_mismatch("interrupt_request", got.irq,
                                                                  want.irq);
                if (got.pad     !== want.pad)     report_mismatch("padding", got.pad, want.pad);
            end
        end
    end

    task automatic test_reset_values();
        foreach (reg_addrs[i]) reg_read(reg_addrs[i]);
        reg_read(7'h7f);
    endtask

    task automatic test_register_access();
        reg_write(ADDR_GIE, 32'hffff_ffff);
        reg_write(ADDR_IER, 32'hffff_ffff);
        reg_write(ADDR_SSR, 32'h0000_0000);
        reg_write(ADDR_CR, 32'hffff_ffff);
        reg_write(ADDR_SR, 32'hffff_ffff);
        reg_write(ADDR_DRR, 32'hffff_ffff);
        reg_write(ADDR_SRR, 32'h0000_000b);
        reg_read(ADDR_CR);
        reg_write(ADDR_SRR, SRR_KEY);
        reg_read(ADDR_SSR);
    endtask

    task automatic test_single_exchange();
        logic [7:0] miso_pattern;
        miso_pattern = 8'h3c;
        reg_write(ADDR_CR, 32'h0000_001e);
        reg_write(ADDR_DTR, 32'hffff_ffa5);
        for (int i = 7; i >= 0; i--) spi_tick(miso_pattern[i]);
        spi_tick(1'b1);
        reg_read(ADDR_DRR);
        reg_read(ADDR_ISR);
        reg_read(ADDR_DRR);
    endtask

    // overflow both FIFOs, clear the flags, and tick while the engine is held off
    task automatic test_fifo_limits();
        reg_write(ADDR_SRR, SRR_KEY);
        reg_write(ADDR_CR, 32'h0000_0006);
        reg_write(ADDR_IER, 32'h0000_003f);
        reg_write(ADDR_GIE, 32'h8000_0000);
        repeat (FIFO_SLOTS + $urandom_range(1, 4)) reg_write(ADDR_DTR, $urandom);
        reg_read(ADDR_SR);
        repeat (FIFO_SLOTS * 8) spi_tick($urandom_range(0, 1));
        reg_read(ADDR_SR);
        repeat (2) reg_write(ADDR_DTR, $urandom);
        repeat (16 + $urandom_range(0, 3)) spi_tick($urandom_range(0, 1));
        reg_read(ADDR_ISR);
        reg_write(ADDR_ISR, $urandom);
        reg_read(ADDR_ISR);
        reg_write(ADDR_ISR, 32'hffff_ffff);
        repeat (FIFO_SLOTS + 1) reg_read(ADDR_DRR);
        drain_results();
        repeat (3) reg_write(ADDR_DTR, $urandom);
        reg_write(ADDR_CR, 32'h0000_0066);
        reg_read(ADDR_SR);
        reg_write(ADDR_CR, 32'h0000_0106);
        reg_write(ADDR_DTR, $urandom);
        repeat (3) spi_tick($urandom_range(0, 1));
        reg_write(ADDR_CR, 32'h0000_0004);
        repeat (2) spi_tick($urandom_range(0, 1));
        reg_write(ADDR_CR, 32'h0000_0002);
        spi_tick(1'b1);
        reg_write(ADDR_CR, 32'h0000_0006);
        repeat (4) spi_tick($urandom_range(0, 1));
        // stop mid-byte, then resume the byte in flight
        reg_write(ADDR_CR, 32'h0000_0106);
        spi_tick(1'b0);
        reg_write(ADDR_CR, 32'h0000_0006);
        repeat (5) spi_tick($urandom_range(0, 1));
        reg_read(ADDR_DRR);
    endtask

    task automatic run_transfer();
        logic [31:0] ctl;
        int          nbytes;
        int          nread;
        int          pick;
        ctl = 32'h0000_0006 | ($urandom & 32'h0000_0099);
        if ($urandom_range(0, 9) == 0) ctl = $urandom & 32'h0000_01ff;
        if ($urandom_range(0, 4) != 0) reg_write(ADDR_CR, ctl);
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 18) : $urandom_range(1, 3);
        repeat (nbytes) reg_write(ADDR_DTR, $urandom);
        repeat (nbytes * 8 + $urandom_range(0, 2)) begin
            pick = $urandom_range(0, 39);
            if (pick < 2)
                reg_read($urandom_range(0, 1) ? ADDR_SR : ADDR_ISR);
            else if (pick == 2)
                reg_write(ADDR_DTR, $urandom);
            else
                spi_tick($urandom_range(0, 1));
        end
        // leave bytes behind now and then so the receive side fills up
        nread = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, nbytes + 1);
        repeat (nread) reg_read(ADDR_DRR);
    endtask

    task automatic test_random_traffic();
        int          pick;
        logic [6:0]  addr;
        logic [31:0] data;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) gap_style = $urandom_range(0, 2) != 0;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                run_transfer();
            end else if (pick < 72) begin
                addr = reg_addrs[$urandom_range(0, 8)];
                data = $urandom;
                if (addr == ADDR_SRR && $urandom_range(0, 1)) data = SRR_KEY;
                reg_write(addr, data);
                if ($urandom_range(0, 1)) reg_read(addr);
            end else if (pick < 86) begin
                reg_read(reg_addrs[$urandom_range(0, 8)]);
            end else if (pick < 97) begin
                send_beat(2'($urandom_range(0, 2)), 7'($urandom), $urandom,
                          $urandom_range(0, 1));
            end else begin
                drain_results();
            end
        end
    endtask

    initial begin : stimulus
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_READ;
        gap_style = 1;
        model_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_register_access();
        test_single_exchange();
        test_fifo_limits();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (predicted_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d reads, %0d writes, %0d ticks, %0d block resets",
                 n_reads, n_writes, n_ticks, soft_resets);
        $display("%0d bytes exchanged, %0d dropped on overrun, %0d results checked",
                 bytes_exchanged, bytes_dropped, results_seen);
        if (mismatch_count == 0 && predicted_replies.size() == 0) begin
            $display("spi_master_fifo_controller_unit_test passed");
        end else begin
            $display("spi_master_fifo_controller_unit_test failed");
        end
        $finish;
    end

endmodule
